>>> design/cfd_pkg.sv
package cfd_pkg;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN_W = 6;
    localparam int CFG_IDX_W   = 2;

    // Default maximum payload size in bytes
    localparam int CFD_MAX_PAYLOAD = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_IDX  = 2'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] STOP_DELIM_RST  = 8'h55;

    // CRC-8 parameters
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    // Controller to datapath commands
    typedef struct packed {
        logic start;      // open a frame: clear index and CRC
        logic ld_len;     // take the length byte
        logic wr_pay;     // store a payload byte
        logic ld_cmd;     // take the command byte
        logic clear;      // drop the frame state
        logic rd_issue;   // read the payload store at the index
        logic out_load;   // load the output register
    } cfd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_match;
        logic len_bad;
        logic len_zero;
        logic pay_done;
        logic crc_ok;
        logic stop_match;
        logic emit_last;
        logic out_free;
    } cfd_status_t;

    // One CRC-8 byte update, MSB first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

>>> design/cfd_if.sv
// Received byte channel
interface cfd_in_if import cfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded frame result channel
interface cfd_out_if import cfd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BYTE_W-1:0]      command;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [BYTE_W-1:0]      payload_byte;
    logic                   payload_valid;
    logic                   last_of_frame;

    modport source (output valid, output command, output frame_length,
                    output payload_byte, output payload_valid,
                    output last_of_frame, input ready);
    modport sink   (input valid, input command, input frame_length,
                    input payload_byte, input payload_valid,
                    input last_of_frame, output ready);
endinterface

// Configuration write channel
interface cfd_cfg_if import cfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/cfd_ram.sv
module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/cfd_ctrl.sv
module cfd_ctrl import cfd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  cfd_status_t status,
    output cfd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LENGTH,
        S_PAYLOAD,
        S_CMD,
        S_CRC,
        S_STOP,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // Bytes are taken in every parse state
    assign rx_ready = (state_reg != S_READ) && (state_reg != S_LOAD);
    assign accept   = rx_valid && rx_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && status.start_match)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_LENGTH;
                end
            end
            S_LENGTH:
            begin
                if (accept)
                begin
                    if (status.len_bad)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ld_len = 1'b1;
                        state_next = status.len_zero ? S_CMD : S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD:
            begin
                if (accept)
                begin
                    cmd.wr_pay = 1'b1;
                    if (status.pay_done)
                    begin
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                if (accept)
                begin
                    cmd.ld_cmd = 1'b1;
                    state_next = S_CRC;
                end
            end
            S_CRC:
            begin
                if (accept)
                begin
                    if (status.crc_ok)
                    begin
                        state_next = S_STOP;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_STOP:
            begin
                if (accept)
                begin
                    if (status.stop_match)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                // wait until the output register can take the next result
                if (status.out_free)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.out_load = 1'b1;
                if (status.emit_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/cfd_datapath.sv
module cfd_datapath import cfd_pkg::*; #(
    parameter int MAX_PAYLOAD = CFD_MAX_PAYLOAD
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfd_cmd_t               cmd,
    output cfd_status_t            status,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [BYTE_W-1:0]      out_command,
    output logic [FRAME_LEN_W-1:0] out_frame_length,
    output logic [BYTE_W-1:0]      out_payload_byte,
    output logic                   out_payload_valid,
    output logic                   out_last_of_frame
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    logic [BYTE_W-1:0] start_delim_reg;
    logic [BYTE_W-1:0] stop_delim_reg;
    logic [LW-1:0]     len_reg;
    logic [AW-1:0]     idx_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] rd_data;
    logic [LW:0]       idx_inc;

    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_command_reg;
    logic [FRAME_LEN_W-1:0] out_frame_length_reg;
    logic [BYTE_W-1:0]      out_payload_byte_reg;
    logic                   out_payload_valid_reg;
    logic                   out_last_of_frame_reg;

    assign idx_inc = (LW + 1)'(idx_reg) + (LW + 1)'(1);

    // Status toward the controller
    always_comb
    begin
        status.start_match = (rx_byte == start_delim_reg);
        status.len_bad     = (rx_byte > BYTE_W'(MAX_PAYLOAD));
        status.len_zero    = (rx_byte == '0);
        status.pay_done    = (idx_inc >= (LW + 1)'(len_reg));
        status.crc_ok      = (rx_byte == crc_reg);
        status.stop_match  = (rx_byte == stop_delim_reg);
        status.emit_last   = (len_reg == '0) || (idx_inc == (LW + 1)'(len_reg));
        status.out_free    = !out_valid_reg || out_ready;
    end

    // Delimiter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delim_reg <= START_DELIM_RST;
            stop_delim_reg  <= STOP_DELIM_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_START_IDX)
            begin
                start_delim_reg <= cfg_data;
            end
            if (cfg_index == CFG_STOP_IDX)
            begin
                stop_delim_reg <= cfg_data;
            end
        end
    end

    // Frame state: length, index, command, running CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            idx_reg <= '0;
            cmd_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            if (cmd.clear)
            begin
                len_reg <= '0;
                idx_reg <= '0;
                cmd_reg <= '0;
                crc_reg <= CRC_INIT;
            end
            else
            begin
                if (cmd.start)
                begin
                    idx_reg <= '0;
                    crc_reg <= CRC_INIT;
                end
                if (cmd.ld_len)
                begin
                    len_reg <= rx_byte[LW-1:0];
                    crc_reg <= crc8_update(CRC_INIT, rx_byte);
                end
                if (cmd.wr_pay)
                begin
                    idx_reg <= status.pay_done ? '0 : idx_inc[AW-1:0];
                    crc_reg <= crc8_update(crc_reg, rx_byte);
                end
                if (cmd.ld_cmd)
                begin
                    cmd_reg <= rx_byte;
                    crc_reg <= crc8_update(crc_reg, rx_byte);
                end
                if (cmd.out_load)
                begin
                    idx_reg <= idx_inc[AW-1:0];
                end
            end
        end
    end

    // Payload store
    cfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_pay),
        .wr_addr (idx_reg),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload; an empty frame gives one zero-payload result
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_command_reg       <= cmd_reg;
            out_frame_length_reg  <= FRAME_LEN_W'(len_reg);
            out_payload_byte_reg  <= (len_reg == '0) ? '0 : rd_data;
            out_payload_valid_reg <= (len_reg != '0);
            out_last_of_frame_reg <= status.emit_last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_command       = out_command_reg;
    assign out_frame_length  = out_frame_length_reg;
    assign out_payload_byte  = out_payload_byte_reg;
    assign out_payload_valid = out_payload_valid_reg;
    assign out_last_of_frame = out_last_of_frame_reg;

endmodule

>>> design/crc8_frame_decoder_top.sv
// CRC-8 framed packet decoder.
// rx carries one received byte per transaction. Frames are laid out as start
// delimiter, length, payload, command, CRC-8 (poly 0x07, init 0), stop
// delimiter; the CRC covers length, payload and command. A bad length, CRC or
// stop byte drops the frame silently and the parser returns to idle.
// tx delivers one transaction per payload byte (a single one for an empty
// frame), each with command and length, last_of_frame on the final one.
// cfg writes the start (index 0) and stop (index 1) delimiters; it is always
// ready and should be used only while the decoder is idle.
// Throughput: one rx byte per cycle while a frame is parsed. After the stop
// byte the controller reads the payload store byte by byte (read issue, then
// output register load for each), and takes no rx byte meanwhile.
// A stalled tx holds the result in the output register and pauses the read
// sequence; rx is taken again once the last result is loaded.
// Reset returns the parser to idle and the delimiters to 0xAA and 0x55.
module crc8_frame_decoder_top import cfd_pkg::*; #(
    parameter int MAX_PAYLOAD = CFD_MAX_PAYLOAD
) (
    input  logic     clk,
    input  logic     rst_n,
    cfd_in_if.sink   rx,
    cfd_out_if.source tx,
    cfd_cfg_if.sink  cfg
);

    cfd_cmd_t    cmd;
    cfd_status_t status;
    logic        cfg_we;

    // Configuration writes always accepted
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .rx_byte           (rx.rx_byte),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .out_ready         (tx.ready),
        .out_valid         (tx.valid),
        .out_command       (tx.command),
        .out_frame_length  (tx.frame_length),
        .out_payload_byte  (tx.payload_byte),
        .out_payload_valid (tx.payload_valid),
        .out_last_of_frame (tx.last_of_frame)
    );

    // No rx byte is taken while results are being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready) |-> !cmd.out_load && !cmd.rd_issue)
        else $error("rx byte accepted during emission");

    // A store read is always followed by an output load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> cmd.out_load)
        else $error("store read not followed by output load");

    // A read is only issued when the pending result will not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (!tx.valid || tx.ready))
        else $error("output register overwritten");

    // An empty-frame result carries zero length and payload, and closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && !tx.payload_valid) |->
            (tx.frame_length == '0) && (tx.payload_byte == '0) && tx.last_of_frame)
        else $error("malformed empty-frame result");

endmodule
